/* rtl/core/lswc_pkg.sv */
package lswc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int WTOTAL_W = 16;
    localparam int QTOTAL_W = 28;
    localparam int COUNT_W  = 16;
    localparam int AGE_W    = 16;
    localparam int SLOT_W   = 4;
    localparam int IDX_W    = 2;
    localparam int CFG_W    = 16;

    localparam logic [SLOT_W-1:0]   WINDOW_LEN   = 4'd15;
    localparam logic [SAMPLE_W-1:0] MIN_VALID    = 12'd5;
    localparam logic [SAMPLE_W:0]   EMPTY_MARGIN = 13'd5;
    localparam logic [SAMPLE_W:0]   RANGE_MARGIN = 13'd100;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 16'hFFFF;
    localparam logic [AGE_W-1:0]    AGE_MAX      = 16'hFFFF;
    localparam logic [AGE_W-1:0]    STALE_RESET  = 16'd10000;
    localparam logic [SAMPLE_W-1:0] MAX_RESET    = 12'hFFF;

    localparam int            DIV_STEPS = SAMPLE_W;
    localparam logic [3:0]    DIV_LAST  = 4'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        LVL_OK      = 2'd0,
        LVL_EMPTY   = 2'd1,
        LVL_STALE   = 2'd2,
        LVL_UNKNOWN = 2'd3
    } t_level;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef enum logic [IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_DRY    = 2'd1,
        CFG_MAX    = 2'd2,
        CFG_STALE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                enable;
        logic [SAMPLE_W-1:0] dry_level;
        logic [SAMPLE_W-1:0] max_level;
        logic [AGE_W-1:0]    stale_limit;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic t_level classify(input logic [SAMPLE_W-1:0] value,
                                        input logic [SAMPLE_W-1:0] dry,
                                        input logic [SAMPLE_W-1:0] max_lvl);
        t_level lvl;
        if (value < MIN_VALID) begin
            lvl = LVL_UNKNOWN;
        end else if ({1'b0, value} <= ({1'b0, dry} + EMPTY_MARGIN)) begin
            lvl = LVL_EMPTY;
        end else if (value >= max_lvl) begin
            lvl = LVL_UNKNOWN;
        end else begin
            lvl = LVL_OK;
        end
        return lvl;
    endfunction

endpackage

/* rtl/core/lswc_if.sv */
interface lswc_in_if import lswc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [SAMPLE_W-1:0] sample;
    logic                sample_ok;

    modport source (output valid, output op, output sample, output sample_ok, input ready);
    modport sink   (input valid, input op, input sample, input sample_ok, output ready);
endinterface

interface lswc_out_if import lswc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          level;
    logic [SAMPLE_W-1:0] average;
    logic                window_done;
    logic                window_accepted;

    modport source (output valid, output level, output average, output window_done,
                    output window_accepted, input ready);
    modport sink   (input valid, input level, input average, input window_done,
                    input window_accepted, output ready);
endinterface

interface lswc_cfg_if import lswc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/lswc_div.sv */
module lswc_div import lswc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [QTOTAL_W-1:0] i_dividend,
    input  logic [COUNT_W-1:0]  i_divisor,
    output t_div_stat           o_stat,
    output logic [SAMPLE_W-1:0] o_quotient
);

    logic                r_busy;
    logic                r_done;
    logic [3:0]          r_cnt;
    logic [COUNT_W-1:0]  r_rem;
    logic [COUNT_W-1:0]  r_divisor;
    logic [SAMPLE_W-1:0] r_work;

    logic [COUNT_W+1:0]  diff;
    logic                ge;

    // The quotient is known to fit in twelve bits, so the upper dividend bits
    // are already below the divisor and seed the remainder directly.
    assign diff = {1'b0, r_rem, r_work[SAMPLE_W-1]} - {2'b00, r_divisor};
    assign ge   = ~diff[COUNT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= i_dividend[QTOTAL_W-1:SAMPLE_W];
            r_work    <= i_dividend[SAMPLE_W-1:0];
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[COUNT_W-1:0] : {r_rem[COUNT_W-2:0], r_work[SAMPLE_W-1]};
            r_work <= {r_work[SAMPLE_W-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_work;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_divisor))
        else $error("Divider remainder reached the divisor.");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("Divider started while busy.");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("Divider done without a finished run.");

endmodule

/* rtl/core/lswc_core.sv */
module lswc_core import lswc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg_regs,
    lswc_in_if.sink              i_smp,
    lswc_out_if.source           o_res,
    output logic                 o_div_start,
    output logic [QTOTAL_W-1:0]  o_div_dividend,
    output logic [COUNT_W-1:0]   o_div_divisor,
    input  t_div_stat            i_div_stat,
    input  logic [SAMPLE_W-1:0]  i_div_quotient
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [WTOTAL_W-1:0] r_window_total, n_window_total;
    logic [SLOT_W-1:0]   r_window_slot, n_window_slot;
    logic [QTOTAL_W-1:0] r_query_total, n_query_total;
    logic [COUNT_W-1:0]  r_query_count, n_query_count;
    logic [AGE_W-1:0]    r_age, n_age;
    t_level              r_held_level, n_held_level;
    logic [SAMPLE_W-1:0] r_held_avg, n_held_avg;
    logic                r_div_query, n_div_query;

    t_level              r_res_level, n_res_level;
    logic [SAMPLE_W-1:0] r_res_avg, n_res_avg;
    logic                r_res_done, n_res_done;
    logic                r_res_acc, n_res_acc;

    logic                r_out_valid, n_out_valid;
    t_level              r_out_level;
    logic [SAMPLE_W-1:0] r_out_avg;
    logic                r_out_done;
    logic                r_out_acc;

    logic                accept;
    logic                out_load;
    logic [WTOTAL_W-1:0] wt_sum;
    logic [SLOT_W-1:0]   slot_inc;
    logic                in_range;
    t_level              q_level;

    assign i_smp.ready = (r_state == S_IDLE);
    assign accept      = i_smp.valid && i_smp.ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    assign wt_sum   = r_window_total + {{(WTOTAL_W-SAMPLE_W){1'b0}}, i_smp.sample};
    assign slot_inc = r_window_slot + 4'd1;
    assign q_level  = classify(i_div_quotient, i_cfg_regs.dry_level, i_cfg_regs.max_level);
    assign in_range = !(({1'b0, i_div_quotient} >= ({1'b0, i_cfg_regs.max_level} + RANGE_MARGIN))
                     || (({1'b0, i_div_quotient} + RANGE_MARGIN) <= {1'b0, i_cfg_regs.dry_level}));

    always_comb begin
        n_state        = r_state;
        n_window_total = r_window_total;
        n_window_slot  = r_window_slot;
        n_query_total  = r_query_total;
        n_query_count  = r_query_count;
        n_age          = r_age;
        n_held_level   = r_held_level;
        n_held_avg     = r_held_avg;
        n_div_query    = r_div_query;
        n_res_level    = r_res_level;
        n_res_avg      = r_res_avg;
        n_res_done     = r_res_done;
        n_res_acc      = r_res_acc;
        o_div_start    = 1'b0;
        o_div_dividend = r_query_total;
        o_div_divisor  = r_query_count;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_level = r_held_level;
                    n_res_avg   = r_held_avg;
                    n_res_done  = 1'b0;
                    n_res_acc   = 1'b0;
                    n_state     = S_DONE;
                    unique case (i_smp.op)
                        OP_SAMPLE: begin
                            if (i_smp.sample_ok) begin
                                n_window_total = wt_sum;
                                if (r_query_count != COUNT_MAX) begin
                                    n_query_total = r_query_total
                                        + {{(QTOTAL_W-SAMPLE_W){1'b0}}, i_smp.sample};
                                    n_query_count = r_query_count + 16'd1;
                                end
                            end
                            if (slot_inc >= WINDOW_LEN) begin
                                o_div_start    = 1'b1;
                                o_div_dividend = {{(QTOTAL_W-WTOTAL_W){1'b0}}, n_window_total};
                                o_div_divisor  = {{(COUNT_W-SLOT_W){1'b0}}, WINDOW_LEN};
                                n_window_total = '0;
                                n_window_slot  = '0;
                                n_div_query    = 1'b0;
                                n_state        = S_DIV;
                            end else begin
                                n_window_slot = slot_inc;
                            end
                        end
                        OP_TICK: begin
                            if (r_age != AGE_MAX) begin
                                n_age = r_age + 16'd1;
                            end
                        end
                        OP_QUERY: begin
                            if (!i_cfg_regs.enable) begin
                                n_res_level = LVL_UNKNOWN;
                            end else if (r_age > i_cfg_regs.stale_limit) begin
                                n_res_level = LVL_STALE;
                            end else if (r_query_count == '0) begin
                                n_res_level = LVL_UNKNOWN;
                            end else begin
                                o_div_start   = 1'b1;
                                n_query_total = '0;
                                n_query_count = '0;
                                n_div_query   = 1'b1;
                                n_state       = S_DIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (i_div_stat.done) begin
                    n_state = S_DONE;
                    if (r_div_query) begin
                        n_res_level = q_level;
                        n_res_avg   = i_div_quotient;
                    end else begin
                        n_res_done = 1'b1;
                        n_res_acc  = in_range;
                        if (in_range) begin
                            n_age        = '0;
                            n_held_avg   = i_div_quotient;
                            n_held_level = q_level;
                            n_res_level  = q_level;
                            n_res_avg    = i_div_quotient;
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_res.valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_window_total <= '0;
            r_window_slot  <= '0;
            r_query_total  <= '0;
            r_query_count  <= '0;
            r_age          <= AGE_MAX;
            r_held_level   <= LVL_UNKNOWN;
            r_held_avg     <= '0;
            r_div_query    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_window_total <= n_window_total;
            r_window_slot  <= n_window_slot;
            r_query_total  <= n_query_total;
            r_query_count  <= n_query_count;
            r_age          <= n_age;
            r_held_level   <= n_held_level;
            r_held_avg     <= n_held_avg;
            r_div_query    <= n_div_query;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_level <= n_res_level;
        r_res_avg   <= n_res_avg;
        r_res_done  <= n_res_done;
        r_res_acc   <= n_res_acc;
        if (out_load) begin
            r_out_level <= r_res_level;
            r_out_avg   <= r_res_avg;
            r_out_done  <= r_res_done;
            r_out_acc   <= r_res_acc;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.level           = r_out_level;
    assign o_res.average         = r_out_avg;
    assign o_res.window_done     = r_out_done;
    assign o_res.window_accepted = r_out_acc;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_stat.done |-> (r_state == S_DIV))
        else $error("Divider finished outside the divide state.");

    a_div_idle_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> !i_div_stat.busy)
        else $error("Divider busy outside the divide state.");

    a_slot_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window_slot < WINDOW_LEN)
        else $error("Window slot ran past the window length.");

    a_empty_query_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_query_count == '0) |-> (r_query_total == '0))
        else $error("Query total held without any counted sample.");

    a_accept_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_acc) |-> r_out_done)
        else $error("Window accepted on a beat that closed no window.");

endmodule

/* rtl/core/level_sensor_window_classifier_top.sv */
// Reservoir level classifier. Every input beat carries a sample, a time tick or a level query and
// yields exactly one result beat. A tick, a query that does not divide and a sample that does not
// close the window have their result registered on acceptance and then loaded into the output
// register, and the input takes the next beat once that load is done. A sample that closes
// the window and a query that divides the accumulators both pass through one shared restoring
// divider that settles one of twelve quotient bits per cycle; its quotient is then registered in
// the result register and loaded into the output register. The input is not ready while an item is
// being worked on. One finished result may wait in the output register while the next item is
// worked on; that item's result then holds the input off until the register drains.
// Configuration writes are taken in any cycle and should only be issued while no item is
// outstanding.
module level_sensor_window_classifier_top import lswc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lswc_cfg_if.sink    i_cfg,
    lswc_in_if.sink     i_smp,
    lswc_out_if.source  o_res
);

    t_cfg                r_cfg;
    t_div_stat           div_stat;
    logic                div_start;
    logic [QTOTAL_W-1:0] div_dividend;
    logic [COUNT_W-1:0]  div_divisor;
    logic [SAMPLE_W-1:0] div_quotient;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= 1'b0;
            r_cfg.dry_level   <= '0;
            r_cfg.max_level   <= MAX_RESET;
            r_cfg.stale_limit <= STALE_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_ENABLE: r_cfg.enable      <= i_cfg.data[0];
                CFG_DRY:    r_cfg.dry_level   <= i_cfg.data[SAMPLE_W-1:0];
                CFG_MAX:    r_cfg.max_level   <= i_cfg.data[SAMPLE_W-1:0];
                CFG_STALE:  r_cfg.stale_limit <= i_cfg.data[AGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lswc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_regs     (r_cfg),
        .i_smp          (i_smp),
        .o_res          (o_res),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .i_div_stat     (div_stat),
        .i_div_quotient (div_quotient)
    );

    lswc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quotient)
    );

endmodule
